// ----- design/h264_sps_size_parser_top_defines.svh -----
`ifndef H264_SPS_SIZE_PARSER_TOP_DEFINES_SVH
`define H264_SPS_SIZE_PARSER_TOP_DEFINES_SVH
// Assertion helpers for the parser.
`define SPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- design/sps_pkg.sv -----
`default_nettype none
package sps_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;
    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  unit_type;
        logic [15:0] width_pixels;
        logic [15:0] height_pixels;
    } t_out;

    localparam logic [4:0] ST_SEARCH = 5'd0, ST_NAL = 5'd1, ST_PROFILE = 5'd2,
        ST_CONSTR = 5'd3, ST_LEVEL = 5'd4, ST_SPSID = 5'd5, ST_CHROMA = 5'd6,
        ST_RESID = 5'd7, ST_DEPTHL = 5'd8, ST_DEPTHC = 5'd9, ST_BYPASS = 5'd10,
        ST_SCALEFLAG = 5'd11, ST_SCALELISTS = 5'd12, ST_LOG2FN = 5'd13,
        ST_POCTYPE = 5'd14, ST_POCLSB = 5'd15, ST_DELTAFLAG = 5'd16,
        ST_OFFNONREF = 5'd17, ST_OFFTB = 5'd18, ST_CYCLEN = 5'd19,
        ST_CYCLEOFF = 5'd20, ST_NUMREF = 5'd21, ST_GAPS = 5'd22,
        ST_WIDTH = 5'd23, ST_HEIGHT = 5'd24;

    localparam logic [2:0] STS_OK = 3'd0, STS_NOT_SPS = 3'd1, STS_NO_START = 3'd2,
        STS_TRUNC = 3'd3, STS_LONG = 3'd4, STS_OVERFLOW = 3'd5;

    localparam logic [4:0]  NAL_SPS = 5'd7;
    localparam logic [15:0] SCAN_RESET = 16'd300;

    function automatic logic [3:0] fixed_width(input logic [4:0] step);
        case (step)
            ST_NAL, ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_SCALELISTS: fixed_width = 4'd8;
            ST_RESID, ST_BYPASS, ST_SCALEFLAG, ST_DELTAFLAG, ST_GAPS: fixed_width = 4'd1;
            default: fixed_width = 4'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ----- design/h264_sps_size_parser_top.sv -----
`default_nettype none
// Channel  | Signals                         | Direction
// request  | i_valid, o_stall, i_req         | in
// result   | o_valid, i_stall, o_rsp         | out
// config   | i_cfg_we, i_cfg_data            | in
// A byte taken during the start code search passes through acceptance
// and output. A byte taken while parsing passes through acceptance, bit
// steps on the shared bit unit, MSB first (fewer if a result ends it),
// and output. A buffer ending with no result re-enters output to raise it.
// Reset is synchronous and active low and restores the scan limit to 300.
// A waiting result holds the block until it is taken.
module h264_sps_size_parser_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire sps_pkg::t_in i_req,
    output logic             o_valid,
    input  wire logic        i_stall,
    output sps_pkg::t_out    o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data
);
    `include "h264_sps_size_parser_top_defines.svh"

    typedef enum logic [2:0] {S_IDLE = 3'b001, S_BITS = 3'b010, S_OUT = 3'b100} t_fsm;

    t_fsm r_fsm, n_fsm;
    logic [15:0] r_limit;
    logic [4:0]  r_step, n_step;
    logic [1:0]  r_zero, n_zero;
    logic [15:0] r_seen, n_seen;
    logic [7:0]  r_prof, n_prof;
    logic [VALUE_WIDTH-1:0] r_cyc, n_cyc, r_wmbs, n_wmbs;
    logic        r_fin, n_fin;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [2:0]  r_bit, n_bit;
    sps_pkg::t_out r_rsp, n_rsp;
    logic        r_have, n_have;

    logic        bu_start, bu_en, bu_done, bu_long;
    logic [3:0]  bu_width;
    logic [VALUE_WIDTH-1:0] bu_value;
    logic [VALUE_WIDTH:0] w_pix, h_pix;

    sps_bit_unit #(.VALUE_WIDTH(VALUE_WIDTH)) u_bits (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(bu_start), .i_width(bu_width),
        .i_bit(r_byte[r_bit]), .i_en(bu_en), .o_done(bu_done), .o_long(bu_long),
        .o_value(bu_value)
    );

    assign o_stall = (r_fsm != S_IDLE);
    assign o_valid = (r_fsm == S_OUT) && r_have;
    assign o_rsp   = r_rsp;
    assign w_pix = {1'b0, r_wmbs} + (VALUE_WIDTH+1)'(1);
    assign h_pix = {1'b0, bu_value} + (VALUE_WIDTH+1)'(1);

    always_comb begin
        n_fsm = r_fsm; n_step = r_step; n_zero = r_zero; n_seen = r_seen;
        n_prof = r_prof; n_cyc = r_cyc; n_wmbs = r_wmbs; n_fin = r_fin;
        n_bit = r_bit; n_rsp = r_rsp; n_have = r_have;
        bu_start = 1'b0; bu_width = 4'd0; bu_en = 1'b0;
        case (r_fsm)
            S_IDLE: begin
                if (i_valid) begin
                    n_have = 1'b0;
                    n_bit = 3'd7;
                    if (r_fin) begin
                        n_fsm = S_OUT;
                    end else if (r_step == sps_pkg::ST_SEARCH) begin
                        n_fsm = S_OUT;
                        if (r_seen != 16'hFFFF) n_seen = r_seen + 16'd1;
                        if (i_req.data_byte == 8'd0) begin
                            if (r_zero != 2'd3) n_zero = r_zero + 2'd1;
                        end else if (i_req.data_byte == 8'd1 && r_zero == 2'd3) begin
                            n_zero = 2'd0;
                            n_step = sps_pkg::ST_NAL;
                            bu_start = 1'b1;
                            bu_width = sps_pkg::fixed_width(sps_pkg::ST_NAL);
                        end else begin
                            n_zero = 2'd0;
                        end
                        if (n_step == sps_pkg::ST_SEARCH && n_seen >= r_limit) begin
                            n_rsp = '{sps_pkg::STS_NO_START, 5'd0, 16'd0, 16'd0};
                            n_have = 1'b1; n_fin = 1'b1;
                        end
                    end else begin
                        n_fsm = S_BITS;
                    end
                end
            end
            S_BITS: begin
                bu_en = 1'b1;
                if (r_bit == 3'd0) n_fsm = S_OUT;
                n_bit = r_bit - 3'd1;
                if (bu_long) begin
                    n_rsp = '{sps_pkg::STS_LONG, sps_pkg::NAL_SPS, 16'd0, 16'd0};
                    n_have = 1'b1; n_fin = 1'b1; n_fsm = S_OUT;
                end else if (bu_done) begin
                    bu_start = 1'b1;
                    case (r_step)
                        sps_pkg::ST_NAL:
                            if (bu_value[4:0] != sps_pkg::NAL_SPS) begin
                                n_rsp = '{sps_pkg::STS_NOT_SPS, bu_value[4:0], 16'd0, 16'd0};
                                n_have = 1'b1; n_fin = 1'b1; n_fsm = S_OUT;
                            end else n_step = sps_pkg::ST_PROFILE;
                        sps_pkg::ST_PROFILE: begin
                            n_prof = bu_value[7:0]; n_step = sps_pkg::ST_CONSTR;
                        end
                        sps_pkg::ST_CONSTR: n_step = sps_pkg::ST_LEVEL;
                        sps_pkg::ST_LEVEL: n_step = sps_pkg::ST_SPSID;
                        sps_pkg::ST_SPSID:
                            n_step = (r_prof == 8'd100 || r_prof == 8'd110 ||
                                      r_prof == 8'd122 || r_prof == 8'd144)
                                     ? sps_pkg::ST_CHROMA : sps_pkg::ST_LOG2FN;
                        sps_pkg::ST_CHROMA:
                            n_step = (bu_value == VALUE_WIDTH'(3))
                                     ? sps_pkg::ST_RESID : sps_pkg::ST_DEPTHL;
                        sps_pkg::ST_RESID: n_step = sps_pkg::ST_DEPTHL;
                        sps_pkg::ST_DEPTHL: n_step = sps_pkg::ST_DEPTHC;
                        sps_pkg::ST_DEPTHC: n_step = sps_pkg::ST_BYPASS;
                        sps_pkg::ST_BYPASS: n_step = sps_pkg::ST_SCALEFLAG;
                        sps_pkg::ST_SCALEFLAG:
                            n_step = (bu_value != '0) ? sps_pkg::ST_SCALELISTS
                                                      : sps_pkg::ST_LOG2FN;
                        sps_pkg::ST_SCALELISTS: n_step = sps_pkg::ST_LOG2FN;
                        sps_pkg::ST_LOG2FN: n_step = sps_pkg::ST_POCTYPE;
                        sps_pkg::ST_POCTYPE:
                            n_step = (bu_value == '0) ? sps_pkg::ST_POCLSB :
                                     (bu_value == VALUE_WIDTH'(1)) ? sps_pkg::ST_DELTAFLAG
                                                                   : sps_pkg::ST_NUMREF;
                        sps_pkg::ST_POCLSB: n_step = sps_pkg::ST_NUMREF;
                        sps_pkg::ST_DELTAFLAG: n_step = sps_pkg::ST_OFFNONREF;
                        sps_pkg::ST_OFFNONREF: n_step = sps_pkg::ST_OFFTB;
                        sps_pkg::ST_OFFTB: n_step = sps_pkg::ST_CYCLEN;
                        sps_pkg::ST_CYCLEN: begin
                            n_cyc = bu_value;
                            n_step = (bu_value == '0) ? sps_pkg::ST_NUMREF
                                                      : sps_pkg::ST_CYCLEOFF;
                        end
                        sps_pkg::ST_CYCLEOFF: begin
                            n_cyc = r_cyc - VALUE_WIDTH'(1);
                            n_step = (n_cyc == '0) ? sps_pkg::ST_NUMREF
                                                   : sps_pkg::ST_CYCLEOFF;
                        end
                        sps_pkg::ST_NUMREF: n_step = sps_pkg::ST_GAPS;
                        sps_pkg::ST_GAPS: n_step = sps_pkg::ST_WIDTH;
                        sps_pkg::ST_WIDTH: begin
                            n_wmbs = bu_value; n_step = sps_pkg::ST_HEIGHT;
                        end
                        sps_pkg::ST_HEIGHT: begin
                            n_have = 1'b1; n_fin = 1'b1; n_fsm = S_OUT;
                            if (w_pix[VALUE_WIDTH:12] != '0 || h_pix[VALUE_WIDTH:12] != '0)
                                n_rsp = '{sps_pkg::STS_OVERFLOW, sps_pkg::NAL_SPS,
                                          16'd0, 16'd0};
                            else
                                n_rsp = '{sps_pkg::STS_OK, sps_pkg::NAL_SPS,
                                          {w_pix[11:0], 4'd0}, {h_pix[11:0], 4'd0}};
                        end
                        default: n_step = r_step;
                    endcase
                    bu_width = sps_pkg::fixed_width(n_step);
                end
            end
            S_OUT: begin
                if (!r_have || !i_stall) begin
                    n_fsm = S_IDLE;
                    n_have = 1'b0;
                    if (r_last) begin
                        if (!r_fin && !r_have) begin
                            n_have = 1'b1; n_fsm = S_OUT;
                            if (r_step == sps_pkg::ST_SEARCH)
                                n_rsp = '{sps_pkg::STS_NO_START, 5'd0, 16'd0, 16'd0};
                            else
                                n_rsp = '{sps_pkg::STS_TRUNC,
                                          (r_step > sps_pkg::ST_NAL) ? sps_pkg::NAL_SPS
                                                                     : 5'd0,
                                          16'd0, 16'd0};
                        end
                        n_fin = 1'b0; n_step = sps_pkg::ST_SEARCH; n_zero = 2'd0;
                        n_seen = 16'd0; n_prof = 8'd0; n_cyc = '0; n_wmbs = '0;
                        if (!r_fin && !r_have) n_fin = 1'b1;
                        if (!(!r_fin && !r_have)) begin
                            n_fin = 1'b0;
                        end
                    end
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE; r_limit <= sps_pkg::SCAN_RESET; r_step <= sps_pkg::ST_SEARCH;
            r_zero <= '0; r_seen <= '0; r_prof <= '0; r_cyc <= '0; r_wmbs <= '0;
            r_fin <= 1'b0; r_have <= 1'b0; r_bit <= '0; r_last <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
            r_fsm <= n_fsm; r_step <= n_step; r_zero <= n_zero; r_seen <= n_seen;
            r_prof <= n_prof; r_cyc <= n_cyc; r_wmbs <= n_wmbs; r_have <= n_have;
            r_bit <= n_bit; r_fin <= n_fin;
            if (i_valid && !o_stall) begin
                r_byte <= i_req.data_byte; r_last <= i_req.last_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    `SPS_ASSERT_IMPL(a_valid_in_out, i_clk, i_rst_n, o_valid, r_fsm == S_OUT)
    `SPS_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_fsm != S_IDLE, o_stall)
    `SPS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_rsp))
endmodule
`default_nettype wire

// ----- design/sps_bit_unit.sv -----
`default_nettype none
// Consumes one bitstream bit per cycle while enabled and tracks fixed and Exp-Golomb fields.
module sps_bit_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [3:0]             i_width,
    input  wire logic                   i_bit,
    input  wire logic                   i_en,
    output logic                        o_done,
    output logic                        o_long,
    output logic [VALUE_WIDTH-1:0]      o_value
);
    localparam int LZW = $clog2(VALUE_WIDTH) + 1;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [LZW-1:0]         r_lz, n_lz;
    logic [3:0]             r_left, n_left;
    logic                   r_fixed, n_fixed;

    always_comb begin
        n_value = r_value; n_lz = r_lz; n_left = r_left; n_fixed = r_fixed;
        o_done = 1'b0; o_long = 1'b0; o_value = '0;
        if (i_en) begin
            if (r_fixed) begin
                n_value = {r_value[VALUE_WIDTH-2:0], i_bit};
                n_left = (r_left != 4'd0) ? r_left - 4'd1 : r_left;
                o_done = (n_left == 4'd0);
                o_value = n_value;
            end else if (r_value == '0) begin
                if (!i_bit) begin
                    if (r_lz >= LZW'(VALUE_WIDTH - 1)) o_long = 1'b1;
                    else n_lz = r_lz + LZW'(1);
                end else begin
                    n_value = VALUE_WIDTH'(1);
                    o_done = (r_lz == '0);
                end
            end else begin
                n_value = {r_value[VALUE_WIDTH-2:0], i_bit};
                n_lz = r_lz - LZW'(1);
                o_done = (n_lz == '0);
                o_value = n_value - VALUE_WIDTH'(1);
            end
        end
        if (i_start) begin
            n_value = '0; n_lz = '0; n_left = i_width; n_fixed = (i_width != 4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0; r_lz <= '0; r_left <= '0; r_fixed <= 1'b0;
        end else begin
            r_value <= n_value; r_lz <= n_lz; r_left <= n_left; r_fixed <= n_fixed;
        end
    end
endmodule
`default_nettype wire
